// ----- hw/rtl/drt_pkg.sv -----
// Package for the divider and reload timer: item types, codes, FSM states
// and the timer period table. No dependencies.
package drt_pkg;

  // Item operation codes. Code 3 is unused and changes nothing.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } opcode_e;

  // Register selects.
  typedef enum logic [1:0] {
    REG_DIV  = 2'd0,
    REG_TIMA = 2'd1,
    REG_TMA  = 2'd2,
    REG_TAC  = 2'd3
  } reg_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CALC = 2'd1,
    ST_EMIT = 2'd2
  } state_e;

  // Input and result items.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  reg_index;
    logic [7:0]  write_data;
    logic [16:0] tick_cycles;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } out_item_t;

  // TAC fields.
  localparam int unsigned TacEnBit = 2;

  // Whole TIMA steps in one tick fit in this many bits (smallest shift 4).
  localparam int unsigned StepsW   = 14;
  // One remainder bit is resolved per iteration.
  localparam int unsigned ModIters = StepsW;
  localparam int unsigned CntW     = $clog2(ModIters);

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic last;
    logic emit;
  } drt_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic need_mod;
  } drt_status_t;

  // Timer period as a shift amount per select: 10, 4, 6 and 8.
  function automatic logic [3:0] period_shift(input logic [1:0] sel);
    logic [3:0] sh;
    case (sel)
      2'd0:    sh = 4'd10;
      2'd1:    sh = 4'd4;
      2'd2:    sh = 4'd6;
      default: sh = 4'd8;
    endcase
    return sh;
  endfunction

endpackage

// ----- hw/rtl/drt_datapath.sv -----
// Datapath of the divider and reload timer: DIV/TIMA/TMA/TAC registers,
// the shift-and-subtract remainder unit and the result registers. Uses drt_pkg.
module drt_datapath import drt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_item_i,
  input  drt_cmd_t    cmd_i,
  output drt_status_t status_o,
  output out_item_t   out_item_o
);

  logic [7:0]        div_sub_q, div_sub_d;
  logic [7:0]        div_q, div_d;
  logic [9:0]        tsub_q, tsub_d;
  logic [7:0]        tima_q, tima_d;
  logic [7:0]        tma_q, tma_d;
  logic [7:0]        tac_q, tac_d;
  logic [StepsW-1:0] dvd_q, dvd_d;
  logic [7:0]        rem_q, rem_d;
  out_item_t         res_q, res_d;
  out_item_t         out_q, out_d;

  logic [17:0]       div_total;
  logic [3:0]        shamt;
  logic [17:0]       t_sum;
  logic [17:0]       t_shifted;
  logic [17:0]       t_mask;
  logic [17:0]       t_rem;
  logic [StepsW-1:0] steps;
  logic [8:0]        to_wrap;
  logic              wraps;
  logic [8:0]        rem_shift;
  logic [8:0]        loop_len;
  logic [8:0]        rem_sub;
  logic [7:0]        rem_nxt;
  logic              is_tick;

  // Tick arithmetic: periods are powers of two, so division is a shift.
  always_comb begin
    div_total = {10'd0, div_sub_q} + {1'b0, in_item_i.tick_cycles};
    shamt     = period_shift(tac_q[1:0]);
    t_sum     = {8'd0, tsub_q} + {1'b0, in_item_i.tick_cycles};
    t_shifted = t_sum >> shamt;
    steps     = t_shifted[StepsW-1:0];
    t_mask    = (18'd1 << shamt) - 18'd1;
    t_rem     = t_sum & t_mask;
    to_wrap   = 9'd256 - {1'b0, tima_q};
    wraps     = steps >= {{(StepsW-9){1'b0}}, to_wrap};
    is_tick   = in_item_i.opcode == OP_TICK;
    status_o.need_mod = is_tick && tac_q[TacEnBit] && wraps;
  end

  // One restoring step of the remainder modulo (256 - TMA).
  always_comb begin
    loop_len  = 9'd256 - {1'b0, tma_q};
    rem_shift = {rem_q, dvd_q[StepsW-1]};
    rem_sub   = rem_shift - loop_len;
    rem_nxt   = (rem_shift >= loop_len) ? rem_sub[7:0] : rem_shift[7:0];
  end

  // Next-state logic for registers and results.
  always_comb begin
    div_sub_d = div_sub_q;
    div_d     = div_q;
    tsub_d    = tsub_q;
    tima_d    = tima_q;
    tma_d     = tma_q;
    tac_d     = tac_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    res_d     = res_q;
    out_d     = out_q;

    if (cmd_i.load) begin
      res_d = '0;
      case (opcode_e'(in_item_i.opcode))
        OP_TICK: begin
          div_d     = div_q + div_total[15:8];
          div_sub_d = div_total[7:0];
          if (tac_q[TacEnBit]) begin
            tsub_d = t_rem[9:0];
            if (!wraps) begin
              tima_d = tima_q + steps[7:0];
            end else begin
              dvd_d = steps - {{(StepsW-9){1'b0}}, to_wrap};
              rem_d = '0;
              res_d.timer_irq = 1'b1;
            end
          end
        end
        OP_READ: begin
          case (reg_e'(in_item_i.reg_index))
            REG_DIV:  res_d.read_data = div_q;
            REG_TIMA: res_d.read_data = tima_q;
            REG_TMA:  res_d.read_data = tma_q;
            default:  res_d.read_data = tac_q;
          endcase
        end
        OP_WRITE: begin
          case (reg_e'(in_item_i.reg_index))
            REG_DIV: begin
              div_d     = '0;
              div_sub_d = '0;
            end
            REG_TIMA: tima_d = in_item_i.write_data;
            REG_TMA:  tma_d  = in_item_i.write_data;
            default:  tac_d  = in_item_i.write_data;
          endcase
        end
        default: ;
      endcase
    end

    // Remainder iteration; the last one reloads TIMA from TMA plus the remainder.
    if (cmd_i.step) begin
      rem_d = rem_nxt;
      dvd_d = {dvd_q[StepsW-2:0], 1'b0};
      if (cmd_i.last) begin
        tima_d = tma_q + rem_nxt;
      end
    end

    if (cmd_i.emit) begin
      out_d = res_q;
    end
  end

  // Architectural registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_sub_q <= '0;
      div_q     <= '0;
      tsub_q    <= '0;
      tima_q    <= '0;
      tma_q     <= '0;
      tac_q     <= '0;
    end else begin
      div_sub_q <= div_sub_d;
      div_q     <= div_d;
      tsub_q    <= tsub_d;
      tima_q    <= tima_d;
      tma_q     <= tma_d;
      tac_q     <= tac_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_item_o = out_q;

endmodule

// ----- hw/rtl/drt_ctrl.sv -----
// Controller of the divider and reload timer: sequences item load, the
// remainder iterations and the output handoff. Uses drt_pkg.
module drt_ctrl import drt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  drt_status_t status_i,
  output drt_cmd_t    cmd_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            slot_free;
  logic            last_iter;

  assign in_ready_o  = state_q == ST_IDLE;
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign last_iter   = cnt_q == CntW'(ModIters - 1);
  assign out_valid_o = out_valid_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = status_i.need_mod ? ST_CALC : ST_EMIT;
        end
      end
      ST_CALC: begin
        if (last_iter) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: datapath commands, iteration count and output valid.
  always_comb begin
    cmd_o       = '0;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = accept;
        cnt_d      = '0;
      end
      ST_CALC: begin
        cmd_o.step = 1'b1;
        cmd_o.last = last_iter;
        cnt_d      = cnt_q + CntW'(1);
      end
      ST_EMIT: begin
        cmd_o.emit = slot_free;
        if (slot_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // An item that needs no remainder goes straight to the handoff.
  a_direct_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !status_i.need_mod |=> state_q == ST_EMIT)
    else $error("item without remainder work did not go to handoff");

  // The remainder unit ends its iterations on the last count.
  a_calc_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC && last_iter |=> state_q == ST_EMIT)
    else $error("remainder iterations did not end on the last count");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC |-> cnt_q < CntW'(ModIters))
    else $error("iteration count out of range");

  // A handoff always leaves a valid result at the output.
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q)
    else $error("result handed off but output not valid");

endmodule

// ----- hw/rtl/divider_and_reload_timer.sv -----
// Top level of the divider and reload timer (DIV, TIMA, TMA, TAC).
// Instantiates drt_ctrl and drt_datapath; uses drt_pkg.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+------------------------
//   in      | input     | in_valid_i / in_ready_o  | in_item_i  (in_item_t)
//   out     | output    | out_valid_o / out_ready_i | out_item_o (out_item_t)
//
// A read, a write, or a tick in which TIMA does not wrap goes from the result
// register to the output register. A tick in which TIMA wraps first runs the
// remainder iterations: the remainder modulo (256 - TMA) is resolved one bit
// per cycle by a single subtractor over 14 iterations. The next item is
// accepted once the current one is handed to the output register, so a
// stalled output holds one result while one more item is worked on.
// Reset clears the architectural and controller registers to zero (timer off,
// period select 0); the working and result payload registers are not reset.
module divider_and_reload_timer import drt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  drt_cmd_t    cmd;
  drt_status_t status;

  // Sequencing.
  drt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Registers and arithmetic.
  drt_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule
